>>> rtl/core/isd_pkg.sv
// Shared constants and types for the serial clock divider search core.
package isd_pkg;

  localparam int unsigned REQ_W     = 20;
  localparam int unsigned CLK_W     = 28;
  localparam int unsigned ICLK_W    = 25;
  localparam int unsigned STEP_W    = 6;
  localparam int unsigned DVSR_W    = 10;
  localparam int unsigned PRE_N     = 4;
  localparam int unsigned LANES     = 2 * PRE_N;
  localparam int unsigned DIV_STEPS = ICLK_W;

  localparam logic [CLK_W-1:0]  CLK_RESET  = 28'd33000000;
  localparam logic [CLK_W-1:0]  ICLK_LIMIT = 28'd20000000;
  localparam logic [29:0]       RECIP3     = 30'd715827883;
  localparam logic [ICLK_W-1:0] BASE_DIV   = 25'd20;
  localparam logic [ICLK_W-1:0] STEP_LIMIT = 25'd63;

  // One restoring division lane: partial remainder, dividend/quotient, divisor.
  typedef struct packed {
    logic [REQ_W-1:0]  rem;
    logic [ICLK_W-1:0] dvd;
    logic [REQ_W-1:0]  dvsr;
  } div_lane_t;

  typedef div_lane_t [LANES-1:0] lane_row_t;

  // Request context that travels alongside the division lanes.
  typedef struct packed {
    logic [REQ_W-1:0]                  req;
    logic [PRE_N-1:0][ICLK_W-1:0]      iclk;
    logic [PRE_N-1:0]                  keep;
    logic [LANES-1:0]                  tried;
    logic [LANES-1:0][STEP_W-1:0]      step;
  } side_t;

endpackage

>>> rtl/core/i2c_scl_divider_search_core.sv
// Top level of the serial clock divider search core.
//
// Usage: write the peripheral clock in hertz through wr_en/wr_data while
// no request is in flight. A request is taken at a rising edge where start
// is high and busy is low; busy is always low, so a new request can be
// issued in every cycle. Each request gives one result: done is high for
// one cycle with divider_word and rejected valid in that cycle.
// Results come out in request order at one per cycle. The input register
// is loaded at the accepting edge; after it come two chains of 25
// restoring division cells (clock over request, then clock over the
// divider), plus clock split, estimate, error and selection stages. The
// receiver cannot hold results off. Reset clears all valid bits in the
// chain and sets the peripheral clock to 33 MHz.
module i2c_scl_divider_search_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [isd_pkg::CLK_W-1:0]  wr_data,
  input  logic                       start,
  output logic                       busy,
  input  logic [isd_pkg::REQ_W-1:0]  requested_rate_hz,
  output logic                       done,
  output logic [7:0]                 divider_word,
  output logic                       rejected
);
  import isd_pkg::*;

  logic [CLK_W-1:0] mck;
  logic             v0;
  logic [REQ_W-1:0] req0;
  logic [CLK_W-1:0] mck0;

  logic [DIV_STEPS:0] q_valid;
  side_t              q_side  [DIV_STEPS+1];
  lane_row_t          q_lanes [DIV_STEPS+1];
  logic [DIV_STEPS:0] r_valid;
  side_t              r_side  [DIV_STEPS+1];
  lane_row_t          r_lanes [DIV_STEPS+1];

  logic [CLK_W+29:0]             prod3;
  logic [PRE_N-1:0][CLK_W-1:0]   iclk_full;
  side_t                         side1_next;
  lane_row_t                     lanes1_next;
  side_t                         side_e_next;
  lane_row_t                     lanes_e_next;

  logic                          ve;
  logic [REQ_W-1:0]              req_e;
  logic [LANES-1:0]              tried_e;
  logic [LANES-1:0][STEP_W-1:0]  step_e;
  logic [LANES-1:0][ICLK_W-1:0]  err_e;
  logic [LANES-1:0][ICLK_W-1:0]  err_next;

  logic [7:0]                    word_next;
  logic                          rej_next;

  assign busy = 1'b0;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mck <= CLK_RESET;
    end else if (wr_en) begin
      mck <= wr_data;
    end
  end

  // Input stage: capture the request with the clock it runs against.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    req0 <= requested_rate_hz;
    mck0 <= mck;
  end

  // Module clocks for each prescaler; divide by three via the reciprocal.
  always_comb begin
    prod3        = {30'd0, mck0} * {{CLK_W{1'b0}}, RECIP3};
    iclk_full[0] = mck0;
    iclk_full[1] = mck0 >> 1;
    iclk_full[2] = {1'b0, prod3[CLK_W+29:31]};
    iclk_full[3] = mck0 >> 2;
    side1_next       = '0;
    side1_next.req   = req0;
    for (int p = 0; p < PRE_N; p++) begin
      side1_next.iclk[p] = iclk_full[p][ICLK_W-1:0];
      side1_next.keep[p] = iclk_full[p] < ICLK_LIMIT;
      lanes1_next[p].rem  = '0;
      lanes1_next[p].dvd  = iclk_full[p][ICLK_W-1:0];
      lanes1_next[p].dvsr = req0;
    end
    // Spare lanes hold a constant zero quotient.
    for (int i = PRE_N; i < LANES; i++) begin
      lanes1_next[i].rem  = '0;
      lanes1_next[i].dvd  = '0;
      lanes1_next[i].dvsr = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid[0] <= 1'b0;
    end else begin
      q_valid[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    q_side[0]  <= side1_next;
    q_lanes[0] <= lanes1_next;
  end

  // First chain: clock over request for each prescaler.
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_qchain
    isd_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (q_valid[g]),
      .in_side   (q_side[g]),
      .in_lanes  (q_lanes[g]),
      .out_valid (q_valid[g+1]),
      .out_side  (q_side[g+1]),
      .out_lanes (q_lanes[g+1])
    );
  end

  // Estimate stage: two candidate steps per prescaler and their divisors.
  always_comb begin
    logic [ICLK_W-1:0] q;
    logic [ICLK_W-1:0] est;
    logic              ok;
    logic [STEP_W-1:0] s0;
    logic [STEP_W-1:0] s1;
    q   = '0;
    est = '0;
    ok  = 1'b0;
    s0  = '0;
    s1  = '0;
    side_e_next = q_side[DIV_STEPS];
    for (int p = 0; p < PRE_N; p++) begin
      q   = q_lanes[DIV_STEPS][p].dvd;
      est = (q - BASE_DIV) >> 3;
      ok  = q_side[DIV_STEPS].keep[p] && (q >= BASE_DIV);
      s0  = est[STEP_W-1:0];
      s1  = s0 + STEP_W'(1);
      side_e_next.tried[2*p]   = ok && (est < STEP_LIMIT);
      side_e_next.tried[2*p+1] = ok && (est < STEP_LIMIT - ICLK_W'(1));
      side_e_next.step[2*p]    = s0;
      side_e_next.step[2*p+1]  = s1;
      lanes_e_next[2*p].rem    = '0;
      lanes_e_next[2*p].dvd    = q_side[DIV_STEPS].iclk[p];
      lanes_e_next[2*p].dvsr   = REQ_W'(DVSR_W'(BASE_DIV) + {1'b0, s0, 3'b000});
      lanes_e_next[2*p+1].rem  = '0;
      lanes_e_next[2*p+1].dvd  = q_side[DIV_STEPS].iclk[p];
      lanes_e_next[2*p+1].dvsr = REQ_W'(DVSR_W'(BASE_DIV) + {1'b0, s1, 3'b000});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid[0] <= 1'b0;
    end else begin
      r_valid[0] <= q_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    r_side[0]  <= side_e_next;
    r_lanes[0] <= lanes_e_next;
  end

  // Second chain: clock over divider for every candidate.
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_rchain
    isd_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (r_valid[g]),
      .in_side   (r_side[g]),
      .in_lanes  (r_lanes[g]),
      .out_valid (r_valid[g+1]),
      .out_side  (r_side[g+1]),
      .out_lanes (r_lanes[g+1])
    );
  end

  // Error stage: distance of each candidate rate from the request.
  always_comb begin
    logic [ICLK_W-1:0] rq;
    logic [ICLK_W-1:0] rt;
    rq = ICLK_W'(r_side[DIV_STEPS].req);
    rt = '0;
    for (int i = 0; i < LANES; i++) begin
      rt          = r_lanes[DIV_STEPS][i].dvd;
      err_next[i] = (rq > rt) ? rq - rt : rt - rq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else begin
      ve <= r_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    req_e   <= r_side[DIV_STEPS].req;
    tried_e <= r_side[DIV_STEPS].tried;
    step_e  <= r_side[DIV_STEPS].step;
    err_e   <= err_next;
  end

  // Selection: highest prescaler first, lower step first, strict improvement.
  always_comb begin
    logic [ICLK_W-1:0] best;
    logic [1:0]        bpre;
    logic [STEP_W-1:0] bstep;
    int                lane;
    best  = ICLK_W'(req_e);
    bpre  = '0;
    bstep = '0;
    lane  = 0;
    for (int j = 0; j < LANES; j++) begin
      lane = (PRE_N - 1 - (j >> 1)) * 2 + (j & 1);
      if (tried_e[lane] && (err_e[lane] < best)) begin
        best  = err_e[lane];
        bpre  = 2'(PRE_N - 1 - (j >> 1));
        bstep = step_e[lane];
      end
    end
    rej_next  = (req_e == '0) || (best > ICLK_W'(req_e >> 2));
    word_next = rej_next ? 8'd0 : {bstep, bpre};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ve;
    end
  end

  always_ff @(posedge clk) begin
    divider_word <= word_next;
    rejected     <= rej_next;
  end

endmodule

>>> rtl/core/isd_div_cell.sv
// One cell of the divider chain: a restoring division step on every lane.
module isd_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  isd_pkg::side_t    in_side,
  input  isd_pkg::lane_row_t in_lanes,
  output logic              out_valid,
  output isd_pkg::side_t    out_side,
  output isd_pkg::lane_row_t out_lanes
);
  import isd_pkg::*;

  lane_row_t lanes_next;

  // Shift in the next dividend bit and subtract the divisor where it fits.
  always_comb begin
    logic [REQ_W:0] t;
    logic [REQ_W:0] dv;
    logic           ge;
    t  = '0;
    dv = '0;
    ge = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      t  = {in_lanes[i].rem, in_lanes[i].dvd[ICLK_W-1]};
      dv = {1'b0, in_lanes[i].dvsr};
      ge = (t >= dv);
      lanes_next[i].dvsr = in_lanes[i].dvsr;
      lanes_next[i].rem  = ge ? REQ_W'(t - dv) : t[REQ_W-1:0];
      lanes_next[i].dvd  = {in_lanes[i].dvd[ICLK_W-2:0], ge};
    end
  end

  // Valid bit is control state; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_side  <= in_side;
    out_lanes <= lanes_next;
  end

endmodule

>>> dv/tb_i2c_scl_divider_search_core.sv
// Self-checking testbench for the serial clock divider search core.
module tb_i2c_scl_divider_search_core;
  timeunit 1ns;
  timeprecision 1ps;
  import isd_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned ITEMS_PER_CLK = 100;

  typedef struct packed {
    logic [7:0] word;
    logic       rej;
  } divider_result_t;

  // Computes the best divider setting for one request at a given clock.
  function automatic divider_result_t best_divider(logic [REQ_W-1:0] req,
                                                   logic [CLK_W-1:0] mck);
    longint unsigned r, err_best, pre_best, step_best, iclk, q, est, rate, err;
    divider_result_t res;
    r = req;
    err_best = r;
    pre_best = 0;
    step_best = 0;
    if (r == 0) begin
      res.word = '0;
      res.rej = 1'b1;
      return res;
    end
    for (int p = PRE_N - 1; p >= 0; p--) begin
      iclk = longint'(mck) / (p + 1);
      if (iclk >= 20000000) continue;
      q = iclk / r;
      if (q < 20) continue;
      est = (q - 20) >> 3;
      for (longint unsigned s = est; s < 63 && s <= est + 1; s++) begin
        rate = iclk / (20 + (s << 3));
        err = (r > rate) ? r - rate : rate - r;
        if (err < err_best) begin
          err_best = err;
          pre_best = p;
          step_best = s;
        end
      end
    end
    if (err_best > (r >> 2)) begin
      res.word = '0;
      res.rej = 1'b1;
    end else begin
      res.word = 8'((step_best << 2) | pre_best);
      res.rej = 1'b0;
    end
    return res;
  endfunction

  // Holds the expected settings of requests still in the pipeline.
  class divider_scoreboard;
    divider_result_t pending[$];
    int errors;
    int checked;

    function void note_request(logic [REQ_W-1:0] req, logic [CLK_W-1:0] mck);
      pending.push_back(best_divider(req, mck));
    endfunction

    function void check_result(logic [7:0] word, logic rej);
      divider_result_t exp_res;
      if (pending.size() == 0) begin
        $error("unexpected result: divider_word=%0d rejected=%0d", word, rej);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      checked++;
      if (word !== exp_res.word) begin
        $error("divider_word: expected %0d, actual %0d", exp_res.word, word);
        errors++;
      end
      if (rej !== exp_res.rej) begin
        $error("rejected: expected %0d, actual %0d", exp_res.rej, rej);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             wr_en = 1'b0;
  logic [CLK_W-1:0] wr_data = '0;
  logic             start = 1'b0;
  logic             busy;
  logic [REQ_W-1:0] requested_rate_hz = '0;
  logic             done;
  logic [7:0]       divider_word;
  logic             rejected;

  logic [CLK_W-1:0] cur_mck = CLK_RESET;
  int unsigned      stall_cycles = 0;
  int unsigned      cfg_count = 0;
  divider_scoreboard sb = new();

  i2c_scl_divider_search_core uut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_data(wr_data), .start(start),
    .busy(busy), .requested_rate_hz(requested_rate_hz), .done(done),
    .divider_word(divider_word), .rejected(rejected)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Observe register writes, accepted requests and results.
  always @(posedge clk) begin
    if (!rst) begin
      if (wr_en) cur_mck = wr_data;
      if (start && !busy) begin
        sb.note_request(requested_rate_hz, cur_mck);
      end
      if (done) begin
        sb.check_result(divider_word, rejected);
      end
      if ((start && !busy) || done) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("i2c_scl_divider_search_core regression: fail");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mostly realistic rates on a rough log scale, with some full-range noise.
  function automatic logic [REQ_W-1:0] random_rate();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return REQ_W'($urandom_range(1000, 10000));
    if (r < 7) return REQ_W'($urandom_range(10000, 100000));
    if (r < 9) return REQ_W'($urandom_range(100000, 1000000));
    return REQ_W'($urandom);
  endfunction

  task automatic send_request(logic [REQ_W-1:0] req);
    int unsigned gap;
    start <= 1'b1;
    requested_rate_hz <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain the pipeline, then write the clock register while idle.
  task automatic write_clock(logic [CLK_W-1:0] mck);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    wr_en <= 1'b1;
    wr_data <= mck;
    @(posedge clk);
    wr_en <= 1'b0;
    cfg_count++;
  endtask

  task automatic random_burst(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        // Long stretch with no gaps between requests.
        start <= 1'b1;
        for (int unsigned k = 0; k < 8; k++) begin
          requested_rate_hz <= random_rate();
          @(posedge clk);
        end
        i += 7;
      end else begin
        send_request(random_rate());
      end
    end
  endtask

  logic [CLK_W-1:0] clock_set[] = '{
    28'd0, 28'd1, 28'd19999999, 28'd20000000, 28'd200000000,
    28'hFFFFFFF, 28'd80000000, 28'd48000000
  };

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests at the reset clock: field extremes, tiny
    // quotients, and estimates that run past the step limit.
    send_request('0);
    send_request(REQ_W'(1));
    send_request(REQ_W'(1000));
    send_request(REQ_W'(1000000));
    send_request('1);
    send_request(REQ_W'(100000));
    send_request(REQ_W'(400000));
    send_request(REQ_W'(2000));
    send_request(REQ_W'(16000));
    send_request(REQ_W'(500000));
    send_request(REQ_W'(825000));
    random_burst(ITEMS_PER_CLK);

    foreach (clock_set[i]) begin
      write_clock(clock_set[i]);
      send_request('0);
      send_request('1);
      send_request(REQ_W'(1000));
      random_burst(ITEMS_PER_CLK);
    end
    write_clock(CLK_W'($urandom_range(1, 200000000)));
    random_burst(ITEMS_PER_CLK / 2);

    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d divider results over %0d clock register settings.",
             sb.checked, cfg_count + 1);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("i2c_scl_divider_search_core regression: pass");
    end else begin
      $display("i2c_scl_divider_search_core regression: fail");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/core/isd_pkg.sv
rtl/core/isd_div_cell.sv
rtl/core/i2c_scl_divider_search_core.sv
dv/tb_i2c_scl_divider_search_core.sv
